### hdl/lcg48_random_generator_assert.svh
// Assertion macros for the 48-bit LCG random generator.
// Used by lcg48_ctrl and lcg48_dp; relies on ports named clock and reset.
`ifndef LCG48_RANDOM_GENERATOR_ASSERT_SVH
`define LCG48_RANDOM_GENERATOR_ASSERT_SVH

// antecedent in this cycle implies consequent in the next
`define LCG48_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define LCG48_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hdl/lcg48_pkg.sv
// Shared types and constants of the 48-bit LCG random generator.
// No dependencies; imported by lcg48_ctrl, lcg48_dp and the top level.
`default_nettype none

package lcg48_pkg;

   localparam int unsigned STATE_W  = 48;
   localparam int unsigned VALUE_W  = 53;
   localparam int unsigned BOUND_W  = 31;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned REQ_W    = 40;
   localparam int unsigned RSP_W    = 56;

   localparam logic [47:0] LCG_MULT    = 48'h0005_DEEC_E66D;
   localparam logic [47:0] LCG_ADD     = 48'h0000_0000_000B;
   localparam logic [31:0] LCG_MULT_LO = 32'hDEEC_E66D;
   localparam logic [2:0]  LCG_MULT_HI = 3'd5;

   localparam logic [4:0]  DIV_LAST_STEP = 5'd30;

   typedef enum logic [1:0] {
      OP_RAW      = 2'd0,
      OP_BOUNDED  = 2'd1,
      OP_FRACTION = 2'd2,
      OP_UNUSED   = 2'd3
   } lcg48_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADV_A,
      ST_ADV_B,
      ST_FRAC_SAVE,
      ST_DIV_INIT,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } lcg48_state_type;

   typedef struct packed {
      logic csr_load;
      logic load;
      logic adv_a;
      logic adv_b;
      logic save_hi;
      logic div_init;
      logic div_step;
      logic out_load;
   } lcg48_cmd_type;

   typedef struct packed {
      logic is_bounded;
      logic is_fraction;
      logic skip;
      logic bound_pow2;
      logic hi_taken;
      logic div_last;
      logic reject;
      logic out_free;
   } lcg48_status_type;

endpackage

`default_nettype wire

### hdl/lcg48_ctrl.sv
// Controller of the 48-bit LCG random generator: sequences draws and division.
// Depends on lcg48_pkg and lcg48_random_generator_assert.svh.
`default_nettype none

`include "lcg48_random_generator_assert.svh"

module lcg48_ctrl import lcg48_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire lcg48_status_type status,
   output      lcg48_cmd_type    cmd
);

   lcg48_state_type state_ff;
   lcg48_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = status.skip ? ST_FINISH : ST_ADV_A;
         end
         ST_ADV_A: begin
            state_in = ST_ADV_B;
         end
         ST_ADV_B: begin
            if (status.is_bounded) begin
               state_in = status.bound_pow2 ? ST_FINISH : ST_DIV_INIT;
            end else if (status.is_fraction && !status.hi_taken) begin
               state_in = ST_FRAC_SAVE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FRAC_SAVE: begin
            state_in = ST_ADV_A;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.reject ? ST_ADV_A : ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            csr_ready    = 1'b1;
            cmd.load     = req_tvalid;
            cmd.csr_load = csr_valid;
         end
         ST_ADV_A:     cmd.adv_a    = 1'b1;
         ST_ADV_B:     cmd.adv_b    = 1'b1;
         ST_FRAC_SAVE: cmd.save_hi  = 1'b1;
         ST_DIV_INIT:  cmd.div_init = 1'b1;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_FINISH:    cmd.out_load = status.out_free;
         default: begin
         end
      endcase
   end

   `LCG48_ASSERT_NEXT(a_adv_pair, cmd.adv_a, cmd.adv_b, "advance split across cycles broken")
   `LCG48_ASSERT_NEXT(a_accept_dispatch, req_tvalid && req_tready, state_ff == ST_DISPATCH,
                      "accepted item not dispatched")
   `LCG48_ASSERT_SAME(a_out_free, cmd.out_load, status.out_free,
                      "result loaded over a waiting item")

endmodule

`default_nettype wire

### hdl/lcg48_dp.sv
// Datapath of the 48-bit LCG random generator: seed, split multiplier,
// remainder unit and result register. Depends on lcg48_pkg and the assert header.
`default_nettype none

`include "lcg48_random_generator_assert.svh"

module lcg48_dp import lcg48_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lcg48_cmd_type    cmd,
   output      lcg48_status_type status,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic [47:0]      csr_data,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [RSP_W-1:0] rsp_tdata
);

   logic [47:0]  state_ff;
   logic [47:0]  acc_ff;
   logic [1:0]   op_ff;
   logic [5:0]   count_ff;
   logic [30:0]  bound_ff;
   logic [25:0]  hi_ff;
   logic         hi_taken_ff;
   logic [30:0]  u_ff;
   logic [30:0]  dividend_ff;
   logic [30:0]  rem_ff;
   logic [4:0]   step_ff;
   logic         rsp_tvalid_ff;
   logic [52:0]  rsp_value_ff;

   logic [55:0]  prod_lo;
   logic [47:0]  acc_in;
   logic [47:0]  prod_mid;
   logic [15:0]  prod_top;
   logic [23:0]  upper_add;
   logic [47:0]  state_in;
   logic [31:0]  trial;
   logic         trial_ge;
   logic [30:0]  rem_in;
   logic [32:0]  check_sum;
   logic [5:0]   count_eff;
   logic [5:0]   shamt;
   logic [47:0]  raw_bits;
   logic [61:0]  pow2_prod;
   logic [52:0]  value_in;
   logic         out_free;

   // first partial product: low half of the seed times low multiplier word
   assign prod_lo  = 56'(state_ff[23:0]) * 56'(LCG_MULT_LO);
   assign acc_in   = prod_lo[47:0] + LCG_ADD;

   // upper partial products, only the bits that survive mod 2^48
   assign prod_mid  = 48'(state_ff[47:24]) * 48'(LCG_MULT_LO[23:0]);
   assign prod_top  = 16'(state_ff[15:0] * 16'(LCG_MULT_HI));
   assign upper_add = prod_mid[23:0] + {prod_top, 8'd0};
   assign state_in  = acc_ff + {upper_add, 24'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LCG_MULT;
      end else if (cmd.csr_load) begin
         state_ff <= csr_data ^ LCG_MULT;
      end else if (cmd.adv_b) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adv_a) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tdata[1:0];
         count_ff <= req_tdata[7:2];
         bound_ff <= req_tdata[38:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_taken_ff <= 1'b0;
      end else if (cmd.load) begin
         hi_taken_ff <= 1'b0;
      end else if (cmd.save_hi) begin
         hi_taken_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save_hi) begin
         hi_ff <= state_ff[47:22];
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign trial    = {rem_ff, dividend_ff[30]};
   assign trial_ge = trial >= {1'b0, bound_ff};
   assign rem_in   = trial_ge ? 31'(trial - {1'b0, bound_ff}) : trial[30:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         u_ff        <= state_ff[47:17];
         dividend_ff <= state_ff[47:17];
         rem_ff      <= '0;
         step_ff     <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[29:0], 1'b0};
         rem_ff      <= rem_in;
         step_ff     <= step_ff + 5'd1;
      end
   end

   assign check_sum = {2'b00, u_ff} - {2'b00, rem_ff} + {2'b00, bound_ff} - 33'd1;

   assign count_eff = (count_ff == 6'd0) ? 6'd1 :
                      (count_ff > 6'd32) ? 6'd32 : count_ff;
   assign shamt     = 6'd48 - count_eff;
   assign raw_bits  = state_ff >> shamt;
   assign pow2_prod = 62'(bound_ff) * 62'(state_ff[47:17]);

   always_comb begin
      value_in = '0;
      case (op_ff)
         OP_RAW:      value_in = 53'(raw_bits);
         OP_BOUNDED: begin
            if (status.skip) begin
               value_in = '0;
            end else if (status.bound_pow2) begin
               value_in = 53'(pow2_prod[61:31]);
            end else begin
               value_in = 53'(rem_ff);
            end
         end
         OP_FRACTION: value_in = {hi_ff, state_ff[47:21]};
         default:     value_in = '0;
      endcase
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= value_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'd0, rsp_value_ff};

   assign status.is_bounded  = op_ff == OP_BOUNDED;
   assign status.is_fraction = op_ff == OP_FRACTION;
   assign status.skip        = (op_ff == OP_UNUSED) ||
                               ((op_ff == OP_BOUNDED) && (bound_ff == '0));
   assign status.bound_pow2  = (bound_ff & (bound_ff - 31'd1)) == '0;
   assign status.hi_taken    = hi_taken_ff;
   assign status.div_last    = step_ff == DIV_LAST_STEP;
   assign status.reject      = |check_sum[32:31];
   assign status.out_free    = out_free;

   `LCG48_ASSERT_NEXT(a_rem_below_bound, cmd.div_step, rem_ff < bound_ff,
                      "remainder not below bound")
   `LCG48_ASSERT_NEXT(a_out_valid, cmd.out_load, rsp_tvalid_ff,
                      "loaded result not presented")

endmodule

`default_nettype wire

### hdl/lcg48_random_generator.sv
// 48-bit linear congruential generator (s' = s * 0x5DEECE66D + 0xB mod 2^48).
// Items are handled one at a time: raw bits and power-of-two bounds take one
// draw, a fraction two, an unused op or zero bound none. A non-power-of-two
// bound runs each draw through the remainder unit and a rejection check; a
// rejected draw adds another attempt. Each draw passes through the split 48-bit
// multiplier in ADV_A then ADV_B, and the remainder unit retires one bit per
// cycle. A result not yet taken holds the generator until it is accepted.
// Seed writes are taken only while no item is in flight.
// Depends on lcg48_pkg, lcg48_ctrl and lcg48_dp.
`default_nettype none

module lcg48_random_generator import lcg48_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   // [1:0] op, [7:2] bit_count, [38:8] bound, [39] zero
   input  wire logic [REQ_W-1:0] req_tdata,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   // [52:0] value, [55:53] zero
   output      logic [RSP_W-1:0] rsp_tdata,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [47:0]      csr_data
);

   lcg48_cmd_type    cmd;
   lcg48_status_type status;

   lcg48_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   lcg48_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### tb/tb_lcg48_random_generator.sv
// Testbench for lcg48_random_generator: directed and random requests with seed reloads.
// A predictor of the 48-bit generator is updated on each accepted item and the
// results are checked in order. Depends on lcg48_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb_lcg48_random_generator import lcg48_pkg::*;;

   localparam logic [47:0] STATE_MASK = 48'hFFFF_FFFF_FFFF;
   localparam int unsigned DRAIN_CYCLES = 80;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // [1:0] op, [7:2] bit_count, [38:8] bound, [39] zero
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [52:0] value, [55:53] zero
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [47:0]          csr_data   = '0;

   logic [47:0]          lcg_state;
   logic [VALUE_W-1:0]   pending_values[$];
   int unsigned          error_count    = 0;
   int unsigned          send_idle_pct  = 0;
   int unsigned          rsp_stall_pct  = 0;

   lcg48_random_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   // advance the generator and take the top k bits
   function automatic logic [31:0] next_bits(input int unsigned k);
      logic [63:0] prod;
      prod = {16'd0, lcg_state} * {16'd0, LCG_MULT} + {16'd0, LCG_ADD};
      lcg_state = prod[47:0];
      return 32'(lcg_state >> (48 - k));
   endfunction

   function automatic logic [VALUE_W-1:0] next_value(input logic [1:0] op,
                                                     input logic [5:0] cnt,
                                                     input logic [30:0] bound);
      int unsigned  k;
      logic [31:0]  bnd;
      logic [31:0]  lim;
      logic [31:0]  u;
      logic [31:0]  r;
      logic [63:0]  hi;
      logic [63:0]  lo;
      logic [63:0]  wide;
      logic [VALUE_W-1:0] v;
      v = '0;
      bnd = {1'b0, bound};
      case (op)
         OP_RAW: begin
            k = cnt;
            if (k < 1) k = 1;
            if (k > 32) k = 32;
            v = VALUE_W'(next_bits(k));
         end
         OP_BOUNDED: begin
            if (bnd != 0) begin
               lim = bnd - 1;
               u = next_bits(31);
               if ((bnd & lim) == 0) begin
                  wide = {32'd0, bnd} * {32'd0, u};
                  v = VALUE_W'(wide >> 31);
               end else begin
                  r = u % bnd;
                  while (u - r + lim >= 32'h8000_0000) begin
                     u = next_bits(31);
                     r = u % bnd;
                  end
                  v = VALUE_W'(r);
               end
            end
         end
         OP_FRACTION: begin
            hi = {32'd0, next_bits(26)};
            lo = {32'd0, next_bits(27)};
            v = VALUE_W'((hi << 27) + lo);
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected value %h", rsp_tdata[VALUE_W-1:0]));
         end else if (rsp_tdata[VALUE_W-1:0] !== pending_values[0]) begin
            report_mismatch($sformatf("value %h, expected %h",
                                      rsp_tdata[VALUE_W-1:0], pending_values[0]));
            void'(pending_values.pop_front());
         end else begin
            void'(pending_values.pop_front());
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [5:0] cnt,
                               input logic [30:0] bound);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, bound, cnt, op};
      do @(posedge clock); while (!req_tready);
      pending_values.push_back(next_value(op, cnt, bound));
   endtask

   task automatic wait_results;
      while (pending_values.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [47:0] seed);
      req_tvalid <= 1'b0;
      wait_results();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= seed;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lcg_state = (seed ^ LCG_MULT) & STATE_MASK;
   endtask

   task automatic test_raw_bits;
      send_request(OP_RAW, 6'd1, 31'h7FFF_FFFF);
      send_request(OP_RAW, 6'd32, 31'd0);
      send_request(OP_RAW, 6'd0, 31'h5555_5555);
      send_request(OP_RAW, 6'd63, 31'h2AAA_AAAA);
      send_request(OP_RAW, 6'd16, 31'd1);
   endtask

   task automatic test_bounded;
      send_request(OP_BOUNDED, 6'd0, 31'd1);
      send_request(OP_BOUNDED, 6'd63, 31'h4000_0000);
      send_request(OP_BOUNDED, 6'd32, 31'h7FFF_FFFF);
      send_request(OP_BOUNDED, 6'd5, 31'd0);
      send_request(OP_BOUNDED, 6'd1, 31'd3);
      send_request(OP_BOUNDED, 6'd7, 31'h4000_0001);
      send_request(OP_BOUNDED, 6'd9, 31'h7FFF_FFFE);
   endtask

   task automatic test_fraction;
      repeat (3) send_request(OP_FRACTION, 6'($urandom()), 31'($urandom()));
   endtask

   task automatic test_unused_op;
      send_request(OP_UNUSED, 6'd63, 31'h7FFF_FFFF);
      send_request(OP_UNUSED, 6'd0, 31'd0);
   endtask

   task automatic test_seed_reload;
      write_seed(48'hFFFF_FFFF_FFFF);
      send_request(OP_RAW, 6'd32, 31'd0);
      send_request(OP_FRACTION, 6'd0, 31'd0);
      write_seed(LCG_MULT);
      send_request(OP_RAW, 6'd32, 31'd0);
      send_request(OP_BOUNDED, 6'd0, 31'd1000);
      write_seed(48'd0);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      logic [1:0]  op;
      logic [5:0]  cnt;
      logic [30:0] bound;
      int unsigned pick;
      write_seed(48'({$urandom(), $urandom()}));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 30)      op = OP_RAW;
         else if (pick < 65) op = OP_BOUNDED;
         else if (pick < 92) op = OP_FRACTION;
         else                op = OP_UNUSED;
         cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32, 1));
         case ($urandom_range(15))
            0, 1:    bound = 31'd1 << $urandom_range(30);
            2, 3:    bound = 31'($urandom_range(100, 1));
            4, 5:    bound = 31'($urandom_range(32'h7FFF_FFFF, 32'h4000_0001));
            15:      bound = 31'd0;
            default: bound = 31'($urandom());
         endcase
         send_request(op, cnt, bound);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      lcg_state = LCG_MULT & STATE_MASK;
      test_raw_bits();
      test_bounded();
      test_fraction();
      test_unused_op();
      test_seed_reload();
      test_random_traffic(138, 0, 0);
      test_random_traffic(138, 61, 0);
      test_random_traffic(138, 0, 61);
      test_random_traffic(138, 31, 31);
      req_tvalid <= 1'b0;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_values.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
